@@ design/lprl_pkg.sv @@
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared constants and types for the longest-prefix route lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lprl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } tbl_wr_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [IDX_W-1:0]  slot;
    } lookup_res_t;

endpackage

`default_nettype wire

@@ design/longest_prefix_route_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// IPv4 route table with longest-prefix match over the active slots.
//
//   Channel  Direction  Handshake            Contents
//   in       request    in_valid / in_stall  mode, entry fields, dest_addr
//   out      result     out_valid/out_stall  found, hop_addr, out_port, match_slot
//   cfg      write      cfg_we               cfg_wdata -> active_entries
//
// A write request returns an all-zero result. A lookup walks the active
// slots, one per cycle, through the single match comparator fed by one
// memory read port. A new request is taken only when the sequencer is idle
// and the result register is empty. Reset clears control state; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup_unit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lprl_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        mode,
    input  wire logic [lprl_pkg::IDX_W-1:0]  entry_index,
    input  wire logic [lprl_pkg::ADDR_W-1:0] entry_prefix,
    input  wire logic [lprl_pkg::ADDR_W-1:0] entry_mask,
    input  wire logic [lprl_pkg::ADDR_W-1:0] entry_next_hop,
    input  wire logic [lprl_pkg::PORT_W-1:0] entry_port,
    input  wire logic [lprl_pkg::ADDR_W-1:0] dest_addr,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             found,
    output logic      [lprl_pkg::ADDR_W-1:0] hop_addr,
    output logic      [lprl_pkg::PORT_W-1:0] out_port,
    output logic      [lprl_pkg::IDX_W-1:0]  match_slot
);

    logic [lprl_pkg::CNT_W-1:0]  active_reg;
    logic [lprl_pkg::CNT_W-1:0]  limit;
    logic                        accept;
    logic                        busy;
    logic                        out_valid_reg;
    logic                        found_reg;
    logic [lprl_pkg::ADDR_W-1:0] hop_reg;
    logic [lprl_pkg::PORT_W-1:0] port_reg;
    logic [lprl_pkg::IDX_W-1:0]  slot_reg;
    logic [lprl_pkg::IDX_W-1:0]  scan_addr;
    logic [lprl_pkg::IDX_W-1:0]  fetch_addr;
    logic [lprl_pkg::ADDR_W-1:0] rd_prefix;
    logic [lprl_pkg::ADDR_W-1:0] rd_mask;
    logic [lprl_pkg::ADDR_W-1:0] rd_hop;
    logic [lprl_pkg::PORT_W-1:0] rd_port;
    lprl_pkg::tbl_wr_t           wr;
    lprl_pkg::lookup_res_t       res;

    assign in_stall = busy || out_valid_reg;
    assign accept   = in_valid && !in_stall;

    assign limit = (active_reg > lprl_pkg::CNT_W'(lprl_pkg::TABLE_DEPTH))
                 ? lprl_pkg::CNT_W'(lprl_pkg::TABLE_DEPTH) : active_reg;

    always_comb
    begin
        wr.en     = accept && (mode == lprl_pkg::MODE_WRITE);
        wr.idx    = entry_index;
        wr.prefix = entry_prefix;
        wr.mask   = entry_mask;
        wr.hop    = entry_next_hop;
        wr.port   = entry_port;
    end

    lprl_table u_table
    (
        .clk        (clk),
        .wr         (wr),
        .scan_addr  (scan_addr),
        .fetch_addr (fetch_addr),
        .rd_prefix  (rd_prefix),
        .rd_mask    (rd_mask),
        .rd_hop     (rd_hop),
        .rd_port    (rd_port)
    );

    lprl_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept && (mode == lprl_pkg::MODE_LOOKUP)),
        .dest       (dest_addr),
        .limit      (limit),
        .rd_prefix  (rd_prefix),
        .rd_mask    (rd_mask),
        .rd_hop     (rd_hop),
        .rd_port    (rd_port),
        .scan_addr  (scan_addr),
        .fetch_addr (fetch_addr),
        .busy       (busy),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (wr.en || res.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            found_reg <= 1'b0;
            hop_reg   <= '0;
            port_reg  <= '0;
            slot_reg  <= '0;
        end
        else if (res.valid)
        begin
            found_reg <= res.found;
            hop_reg   <= res.hop;
            port_reg  <= res.port;
            slot_reg  <= res.slot;
        end
    end

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign hop_addr   = hop_reg;
    assign out_port   = port_reg;
    assign match_slot = slot_reg;

endmodule

`default_nettype wire

@@ design/lprl_table.sv @@
// ----------------------------------------------------------------------------
// lprl_table
// Route table memories: a match memory read by the scan and a result memory
// read at the winning slot. One write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_table
(
    input  wire logic                        clk,
    input  wire lprl_pkg::tbl_wr_t           wr,
    input  wire logic [lprl_pkg::IDX_W-1:0]  scan_addr,
    input  wire logic [lprl_pkg::IDX_W-1:0]  fetch_addr,
    output logic      [lprl_pkg::ADDR_W-1:0] rd_prefix,
    output logic      [lprl_pkg::ADDR_W-1:0] rd_mask,
    output logic      [lprl_pkg::ADDR_W-1:0] rd_hop,
    output logic      [lprl_pkg::PORT_W-1:0] rd_port
);

    logic [2*lprl_pkg::ADDR_W-1:0]             match_mem  [lprl_pkg::TABLE_DEPTH];
    logic [lprl_pkg::ADDR_W+lprl_pkg::PORT_W-1:0] result_mem [lprl_pkg::TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            match_mem[wr.idx]  <= {wr.mask, wr.prefix};
            result_mem[wr.idx] <= {wr.hop, wr.port};
        end
        {rd_mask, rd_prefix} <= match_mem[scan_addr];
        {rd_hop, rd_port}    <= result_mem[fetch_addr];
    end

endmodule

`default_nettype wire

@@ design/lprl_scan.sv @@
// ----------------------------------------------------------------------------
// lprl_scan
// Lookup sequencer: walks the active slots with one shared comparator,
// keeps the best match, then fetches the winner's next hop and port.
// ----------------------------------------------------------------------------
`default_nettype none

module lprl_scan
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [lprl_pkg::ADDR_W-1:0] dest,
    input  wire logic [lprl_pkg::CNT_W-1:0]  limit,
    input  wire logic [lprl_pkg::ADDR_W-1:0] rd_prefix,
    input  wire logic [lprl_pkg::ADDR_W-1:0] rd_mask,
    input  wire logic [lprl_pkg::ADDR_W-1:0] rd_hop,
    input  wire logic [lprl_pkg::PORT_W-1:0] rd_port,
    output logic      [lprl_pkg::IDX_W-1:0]  scan_addr,
    output logic      [lprl_pkg::IDX_W-1:0]  fetch_addr,
    output logic                             busy,
    output lprl_pkg::lookup_res_t            res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_RESULT
    } state_t;

    state_t                        state_reg, state_next;
    logic [lprl_pkg::CNT_W-1:0]    iss_reg, iss_next;
    logic [lprl_pkg::CNT_W-1:0]    limit_reg, limit_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic [lprl_pkg::IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                          hit_reg, hit_next;
    logic [lprl_pkg::IDX_W-1:0]    best_reg, best_next;
    logic [lprl_pkg::ADDR_W-1:0]   best_mask_reg, best_mask_next;
    logic [lprl_pkg::ADDR_W-1:0]   dest_reg, dest_next;
    logic                          match;

    assign match      = ((dest_reg & rd_mask) == rd_prefix);
    assign scan_addr  = iss_reg[lprl_pkg::IDX_W-1:0];
    assign fetch_addr = best_reg;
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        limit_next     = limit_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        best_next      = best_reg;
        best_mask_next = best_mask_reg;
        dest_next      = dest_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    iss_next   = '0;
                    limit_next = limit;
                    dest_next  = dest;
                    hit_next   = 1'b0;
                    best_next  = '0;
                    best_mask_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (iss_reg < limit_reg)
                begin
                    iss_next       = iss_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = iss_reg[lprl_pkg::IDX_W-1:0];
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = ST_FETCH;
                end
                if (cmp_valid_reg && match && (!hit_reg || (rd_mask > best_mask_reg)))
                begin
                    hit_next       = 1'b1;
                    best_next      = cmp_idx_reg;
                    best_mask_next = rd_mask;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            iss_reg       <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            iss_reg       <= iss_next;
            limit_reg     <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg   <= cmp_idx_next;
        best_reg      <= best_next;
        best_mask_reg <= best_mask_next;
        dest_reg      <= dest_next;
    end

    always_comb
    begin
        res.valid = (state_reg == ST_RESULT);
        res.found = hit_reg;
        res.hop   = hit_reg ? rd_hop : '0;
        res.port  = hit_reg ? rd_port : '0;
        res.slot  = hit_reg ? best_reg : '0;
    end

endmodule

`default_nettype wire
